// ===== sv/page_table_walker_macros.svh =====
// assertion macros for the page table walker
// expects clk and rst in the scope where the macros are used
`ifndef PAGE_TABLE_WALKER_MACROS_SVH
`define PAGE_TABLE_WALKER_MACROS_SVH

// check that holds in the same cycle as its condition
`define PTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page_table_walker: same-cycle check failed");

// check that holds in the cycle after its condition
`define PTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page_table_walker: next-cycle check failed");

`endif

// ===== sv/ptw_pkg.sv =====
// shared types, constants and helper functions of the page table walker
// no dependencies; used by every module of the block
package ptw_pkg;

  localparam int PA_W       = 52;
  localparam int VA_W       = 57;
  localparam int ENTRY_W    = 64;
  localparam int IDX_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 52;
  localparam int PHYS_ADDR_BITS_DEF = 52;

  typedef logic [PA_W-1:0] pa_t;
  typedef logic [VA_W-1:0] va_t;
  typedef logic [2:0]      level_t;

  // input beat kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_ENTRY   = 1'b1;

  // result beat kinds
  localparam logic RES_READ = 1'b0;
  localparam logic RES_DONE = 1'b1;

  // walk status
  localparam logic STATUS_MAPPED = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ROOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIVE_LEVEL = 1'b1;

  // table levels
  localparam level_t LVL_NONE = 3'd0;
  localparam level_t LVL_1    = 3'd1;
  localparam level_t LVL_2    = 3'd2;
  localparam level_t LVL_3    = 3'd3;
  localparam level_t LVL_4    = 3'd4;
  localparam level_t LVL_5    = 3'd5;

  // entry word bit positions
  localparam int ENTRY_PRESENT_BIT = 0;
  localparam int ENTRY_LARGE_BIT   = 7;

  localparam pa_t PAGE_MASK = 52'hFFF;

  typedef struct packed {
    logic                 kind;
    logic [VA_W-1:0]      virtual_address;
    logic [ENTRY_W-1:0]   entry_word;
  } ptw_in_t;

  typedef struct packed {
    logic       result_kind;
    pa_t        read_address;
    pa_t        physical_address;
    level_t     page_level;
    logic       status;
  } ptw_out_t;

  // walk context carried between beats
  typedef struct packed {
    logic   busy;
    level_t level;
    va_t    sva;
    pa_t    table_base;
  } walk_state_t;

  // page offset mask for a mapping that ends at a level
  function automatic pa_t offset_mask(input level_t level);
    pa_t m;
    case (level)
      LVL_2:   m = 52'h1FFFFF;
      LVL_3:   m = 52'h3FFFFFFF;
      LVL_4:   m = 52'h7FFFFFFFFF;
      LVL_5:   m = 52'hFFFFFFFFFFFF;
      default: m = PAGE_MASK;
    endcase
    return m;
  endfunction

  // 9-bit table index of a virtual address at a level
  function automatic logic [IDX_W-1:0] level_index(input va_t va, input level_t level);
    logic [IDX_W-1:0] idx;
    case (level)
      LVL_1:   idx = va[20:12];
      LVL_2:   idx = va[29:21];
      LVL_3:   idx = va[38:30];
      LVL_4:   idx = va[47:39];
      LVL_5:   idx = va[56:48];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// ===== sv/ptw_step.sv =====
// one walk step: next walk context and result beat for one input beat
// depends on ptw_pkg
module ptw_step #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  ptw_pkg::ptw_in_t            item,
  input  ptw_pkg::walk_state_t        walk,
  input  logic                        five_level,
  input  logic [PHYS_ADDR_BITS-1:0]   table_root,
  output ptw_pkg::walk_state_t        walk_next,
  output logic                        emit,
  output ptw_pkg::ptw_out_t           result
);

  localparam ptw_pkg::pa_t PHYS_MASK =
    ptw_pkg::pa_t'((65'd1 << PHYS_ADDR_BITS) - 65'd1);

  ptw_pkg::pa_t    entry_addr;
  ptw_pkg::pa_t    om;
  ptw_pkg::pa_t    mapped_pa;
  ptw_pkg::level_t start_level;
  ptw_pkg::level_t down_level;
  ptw_pkg::pa_t    start_read;
  ptw_pkg::pa_t    down_read;
  logic            present;
  logic            big_page;
  logic            in_range;

  // entry decode
  assign entry_addr = item.entry_word[ptw_pkg::PA_W-1:0] & PHYS_MASK;
  assign present    = item.entry_word[ptw_pkg::ENTRY_PRESENT_BIT];
  assign in_range   = (walk.level >= ptw_pkg::LVL_1) && (walk.level <= ptw_pkg::LVL_5);
  assign big_page   = item.entry_word[ptw_pkg::ENTRY_LARGE_BIT]
                      && (walk.level != ptw_pkg::LVL_1)
                      && ((walk.level != ptw_pkg::LVL_4) || five_level);

  // final address: page base from the entry plus the virtual offset
  assign om        = ptw_pkg::offset_mask(walk.level);
  assign mapped_pa = ((entry_addr & ~om) + (walk.sva[ptw_pkg::PA_W-1:0] & om)) & PHYS_MASK;

  // entry read at the top table for a new request
  assign start_level = five_level ? ptw_pkg::LVL_5 : ptw_pkg::LVL_4;
  assign start_read  = ((ptw_pkg::pa_t'(table_root) & PHYS_MASK & ~ptw_pkg::PAGE_MASK)
                        + ptw_pkg::pa_t'({ptw_pkg::level_index(item.virtual_address,
                                                               start_level), 3'b000}))
                       & PHYS_MASK;

  // entry read one level down, in the table the entry points to
  assign down_level = walk.level - 3'd1;
  assign down_read  = ((entry_addr & ~ptw_pkg::PAGE_MASK)
                       + ptw_pkg::pa_t'({ptw_pkg::level_index(walk.sva, down_level),
                                         3'b000})) & PHYS_MASK;

  // step decision
  always_comb begin
    walk_next               = walk;
    emit                    = 1'b0;
    result.result_kind      = ptw_pkg::RES_READ;
    result.read_address     = '0;
    result.physical_address = '0;
    result.page_level       = walk.level;
    result.status           = ptw_pkg::STATUS_MAPPED;
    if (item.kind == ptw_pkg::KIND_REQUEST) begin
      walk_next.busy       = 1'b1;
      walk_next.sva        = item.virtual_address;
      walk_next.level      = start_level;
      walk_next.table_base = ptw_pkg::pa_t'(table_root);
      emit                 = 1'b1;
      result.read_address  = start_read;
      result.page_level    = start_level;
    end else if (walk.busy) begin
      if (!in_range) begin
        walk_next.busy  = 1'b0;
        walk_next.level = ptw_pkg::LVL_NONE;
      end else if (!present) begin
        walk_next.busy     = 1'b0;
        emit               = 1'b1;
        result.result_kind = ptw_pkg::RES_DONE;
        result.status      = ptw_pkg::STATUS_ABSENT;
      end else if (walk.level == ptw_pkg::LVL_1 || big_page) begin
        walk_next.busy          = 1'b0;
        emit                    = 1'b1;
        result.result_kind      = ptw_pkg::RES_DONE;
        result.physical_address = mapped_pa;
      end else begin
        walk_next.table_base = entry_addr & ~ptw_pkg::PAGE_MASK;
        walk_next.level      = down_level;
        emit                 = 1'b1;
        result.read_address  = down_read;
        result.page_level    = down_level;
      end
    end
  end

endmodule

// ===== sv/ptw_out_reg.sv =====
// output register for result beats; frees the input side each cycle the beat moves
// depends on ptw_pkg
module ptw_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ptw_pkg::ptw_out_t load_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output ptw_pkg::ptw_out_t out_data
);

  logic out_valid_next;

  // room for a new beat when empty or when the held beat leaves now
  assign space = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== sv/page_table_walker.sv =====
// page table walker: four- or five-level radix table walk, one level per beat
// top level; depends on ptw_pkg, ptw_step, ptw_out_reg and page_table_walker_macros.svh
//
// usage
//   cfg_write/cfg_index/cfg_data set table_root (index 0) and five_level (index 1);
//   these are to be written while the walker is idle; the block does not enforce it.
//   in channel: a request beat (kind 0) starts a walk at the top table; each entry
//   beat (kind 1) returned from memory advances the walk by one level.
//   out channel: each beat gives either the next entry read or the finished
//   translation with its level and status. Entry beats while no walk is open
//   give no result; a request during a walk restarts it.
//   results are registered: a result appears in the cycle after its input beat is accepted.
//   throughput: one input beat per cycle; the only limit is the output register,
//   which takes a new beat whenever it is empty or its beat is taken that cycle.
//   receiver stall: the result is held, and in_ready drops until it is taken.
//   reset: clears the walk, the registers and the output register; in_ready is
//   high in the first cycle after reset.
`include "page_table_walker_macros.svh"

module page_table_walker #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ptw_pkg::ptw_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ptw_pkg::ptw_out_t                   out_data
);

  logic [PHYS_ADDR_BITS-1:0] table_root;
  logic                      five_level;
  ptw_pkg::walk_state_t      walk;
  ptw_pkg::walk_state_t      walk_next;
  logic                      emit;
  ptw_pkg::ptw_out_t         step_result;
  logic                      accept;

  assign accept = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_root <= '0;
      five_level <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ptw_pkg::REG_TABLE_ROOT: table_root <= cfg_data[PHYS_ADDR_BITS-1:0];
        ptw_pkg::REG_FIVE_LEVEL: five_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // walk context
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (accept) begin
      walk <= walk_next;
    end
  end

  ptw_step #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_step (
    .item       (in_data),
    .walk       (walk),
    .five_level (five_level),
    .table_root (table_root),
    .walk_next  (walk_next),
    .emit       (emit),
    .result     (step_result)
  );

  ptw_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && emit),
    .load_data (step_result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an open walk always sits at a real table level
  `PTW_ASSERT_NOW(a_busy_level, walk.busy, (walk.level >= ptw_pkg::LVL_1) && (walk.level <= ptw_pkg::LVL_5))

  // a request opens a walk and leaves a read beat behind
  `PTW_ASSERT_NEXT(a_request_read, accept && (in_data.kind == ptw_pkg::KIND_REQUEST), walk.busy && out_valid && (out_data.result_kind == ptw_pkg::RES_READ))

  // every result beat names a real level
  `PTW_ASSERT_NOW(a_out_level, out_valid, (out_data.page_level >= ptw_pkg::LVL_1) && (out_data.page_level <= ptw_pkg::LVL_5))

endmodule

// ===== tb/sv/page_table_walker_checker.sv =====
// result checker for the page table walker: tracks register writes and input beats,
// predicts each result beat and compares it field by field with what the block sends
// depends on ptw_pkg; instantiated next to the block by page_table_walker_tb
`timescale 1ns / 100ps

module page_table_walker_checker #(
  parameter int PHYS_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ptw_pkg::ptw_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ptw_pkg::ptw_out_t              out_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             reads_seen,
  output int                             finished_seen,
  output int                             absent_seen
);

  localparam logic [63:0] PHYS_MASK   = (64'd1 << PHYS_BITS) - 64'd1;
  localparam logic [63:0] PAGE_OFFSET = 64'hFFF;
  localparam logic [63:0] INDEX_MASK  = 64'h1FF;

  // walk context and register copies
  logic              walk_open;
  ptw_pkg::level_t   walk_level;
  ptw_pkg::va_t      walk_va;
  ptw_pkg::pa_t      walk_base;
  ptw_pkg::pa_t      root_reg;
  logic              five_reg;

  // result beats still owed by the block, oldest first
  ptw_pkg::ptw_out_t due_results[$];

  int mismatches;
  int reads;
  int finishes;
  int absents;

  // bit position of the lowest virtual address bit that indexes a level
  function automatic int level_shift(input ptw_pkg::level_t lvl);
    return 12 + 9 * (int'(lvl) - 1);
  endfunction

  // read of the entry for the current level and table
  function automatic ptw_pkg::ptw_out_t entry_read();
    logic [63:0]       idx;
    ptw_pkg::ptw_out_t beat;
    idx = (64'(walk_va) >> level_shift(walk_level)) & INDEX_MASK;
    beat = '0;
    beat.result_kind  = ptw_pkg::RES_READ;
    beat.read_address = ptw_pkg::pa_t'(((64'(walk_base) & PHYS_MASK & ~PAGE_OFFSET)
                                        + (idx << 3)) & PHYS_MASK);
    beat.page_level   = walk_level;
    return beat;
  endfunction

  function automatic ptw_pkg::ptw_out_t walk_done(input logic [63:0] pa,
                                                  input ptw_pkg::level_t lvl,
                                                  input logic st);
    ptw_pkg::ptw_out_t beat;
    beat = '0;
    beat.result_kind      = ptw_pkg::RES_DONE;
    beat.physical_address = ptw_pkg::pa_t'(pa & PHYS_MASK);
    beat.page_level       = lvl;
    beat.status           = st;
    return beat;
  endfunction

  // one input beat moves the walk on and owes at most one result beat
  task automatic advance_walk(input ptw_pkg::ptw_in_t beat);
    logic [63:0]     word;
    logic [63:0]     span;
    ptw_pkg::level_t lvl;
    logic            big_page;
    if (beat.kind == ptw_pkg::KIND_REQUEST) begin
      walk_va    = beat.virtual_address;
      walk_level = five_reg ? ptw_pkg::LVL_5 : ptw_pkg::LVL_4;
      walk_base  = root_reg;
      walk_open  = 1'b1;
      due_results.push_back(entry_read());
    end else if (walk_open) begin
      word = beat.entry_word;
      lvl  = walk_level;
      if (lvl < ptw_pkg::LVL_1 || lvl > ptw_pkg::LVL_5) begin
        // walk with a broken level is dropped silently
        walk_open  = 1'b0;
        walk_level = ptw_pkg::LVL_NONE;
      end else if (!word[ptw_pkg::ENTRY_PRESENT_BIT]) begin
        walk_open = 1'b0;
        due_results.push_back(walk_done(64'd0, lvl, ptw_pkg::STATUS_ABSENT));
      end else if (lvl == ptw_pkg::LVL_1) begin
        walk_open = 1'b0;
        due_results.push_back(walk_done((word & PHYS_MASK & ~PAGE_OFFSET)
                                        + (64'(walk_va) & PAGE_OFFSET),
                                        ptw_pkg::LVL_1, ptw_pkg::STATUS_MAPPED));
      end else begin
        // large page bit means nothing at level 4 of a four-level walk
        big_page = word[ptw_pkg::ENTRY_LARGE_BIT] && !(lvl == ptw_pkg::LVL_4 && !five_reg);
        if (big_page) begin
          span = (64'd1 << level_shift(lvl)) - 64'd1;
          walk_open = 1'b0;
          due_results.push_back(walk_done((word & PHYS_MASK & ~span) + (64'(walk_va) & span),
                                          lvl, ptw_pkg::STATUS_MAPPED));
        end else begin
          walk_base  = ptw_pkg::pa_t'(word & PHYS_MASK & ~PAGE_OFFSET);
          walk_level = lvl - 3'd1;
          due_results.push_back(entry_read());
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // compare a result beat with the oldest one owed
  task automatic check_result(input ptw_pkg::ptw_out_t got);
    ptw_pkg::ptw_out_t want;
    if (due_results.size() == 0) begin
      report_mismatch("unexpected result beat (result_kind)", 64'(got.result_kind), 64'd0);
    end else begin
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      if (got.read_address !== want.read_address)
        report_mismatch("read_address", 64'(got.read_address), 64'(want.read_address));
      if (got.physical_address !== want.physical_address)
        report_mismatch("physical_address", 64'(got.physical_address),
                        64'(want.physical_address));
      if (got.page_level !== want.page_level)
        report_mismatch("page_level", 64'(got.page_level), 64'(want.page_level));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (want.result_kind == ptw_pkg::RES_READ) reads++;
      else finishes++;
      if (want.result_kind == ptw_pkg::RES_DONE && want.status == ptw_pkg::STATUS_ABSENT)
        absents++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      walk_open  = 1'b0;
      walk_level = ptw_pkg::LVL_NONE;
      walk_va    = '0;
      walk_base  = '0;
      root_reg   = '0;
      five_reg   = 1'b0;
      mismatches = 0;
      due_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ptw_pkg::REG_TABLE_ROOT: root_reg = ptw_pkg::pa_t'(cfg_data);
          ptw_pkg::REG_FIVE_LEVEL: five_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) advance_walk(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    fail_count    <= mismatches;
    pending_count <= due_results.size();
    reads_seen    <= reads;
    finished_seen <= finishes;
    absent_seen   <= absents;
  end

endmodule

// ===== tb/sv/page_table_walker_tb.sv =====
// testbench top for the page table walker: clock, reset, register writes and walk stimulus
// depends on ptw_pkg, the page_table_walker block and page_table_walker_checker
`timescale 1ns / 100ps

module page_table_walker_tb;

  localparam logic [63:0] TABLE_ENTRY = 64'hFFFF_FFFF_FFFF_FF7F;
  localparam logic [63:0] FULL_ENTRY  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          PHASE_ITEMS = 125;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [ptw_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ptw_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  ptw_pkg::ptw_in_t               in_data;
  logic                           out_valid;
  logic                           out_ready;
  ptw_pkg::ptw_out_t              out_data;

  int fail_count;
  int pending_count;
  int reads_seen;
  int finished_seen;
  int absent_seen;

  int   items_sent;
  int   settings_used;
  logic cur_five;
  logic gaps_on;
  logic stall_on;

  page_table_walker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  page_table_walker_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .reads_seen    (reads_seen),
    .finished_seen (finished_seen),
    .absent_seen   (absent_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic ptw_pkg::va_t random_va();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return ptw_pkg::va_t'({$urandom, $urandom});
  endfunction

  // receiver stalls
  initial begin
    int hold;
    out_ready = 1'b0;
    forever begin
      hold = stall_on ? pick_gap() : 0;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // present one input beat and hold it until taken
  task automatic send_beat(input ptw_pkg::ptw_in_t beat);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_request(input ptw_pkg::va_t va);
    ptw_pkg::ptw_in_t beat;
    beat.kind            = ptw_pkg::KIND_REQUEST;
    beat.virtual_address = va;
    beat.entry_word      = {$urandom, $urandom};
    items_sent++;
    send_beat(beat);
  endtask

  task automatic send_entry(input logic [63:0] word);
    ptw_pkg::ptw_in_t beat;
    beat.kind            = ptw_pkg::KIND_ENTRY;
    beat.virtual_address = ptw_pkg::va_t'({$urandom, $urandom});
    beat.entry_word      = word;
    items_sent++;
    send_beat(beat);
  endtask

  // entry word with no walk open; the block ignores it
  task automatic send_stray(input logic [63:0] word);
    ptw_pkg::ptw_in_t beat;
    beat.kind            = ptw_pkg::KIND_ENTRY;
    beat.virtual_address = '0;
    beat.entry_word      = word;
    send_beat(beat);
  endtask

  // drop valid, wait for every owed result, then let ignored beats drain
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input ptw_pkg::pa_t root, input logic five);
    cfg_write <= 1'b1;
    cfg_index <= ptw_pkg::REG_TABLE_ROOT;
    cfg_data  <= root;
    @(posedge clk);
    cfg_index <= ptw_pkg::REG_FIVE_LEVEL;
    cfg_data  <= ptw_pkg::CFG_DATA_W'(five);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_five = five;
    settings_used++;
  endtask

  // full walk with random entries; mostly well formed, sometimes cut short
  task automatic random_walk();
    ptw_pkg::level_t lvl;
    logic [63:0]     word;
    logic            stop;
    send_request(random_va());
    lvl  = cur_five ? ptw_pkg::LVL_5 : ptw_pkg::LVL_4;
    stop = 1'b0;
    while (!stop) begin
      // abandoned walk: the next request restarts
      if ($urandom_range(0, 99) < 4) return;
      word = {$urandom, $urandom};
      word[ptw_pkg::ENTRY_PRESENT_BIT] = ($urandom_range(0, 9) != 0);
      word[ptw_pkg::ENTRY_LARGE_BIT]   = ($urandom_range(0, 3) == 0);
      send_entry(word);
      if (!word[ptw_pkg::ENTRY_PRESENT_BIT] || lvl == ptw_pkg::LVL_1
          || (word[ptw_pkg::ENTRY_LARGE_BIT] && !(lvl == ptw_pkg::LVL_4 && !cur_five)))
        stop = 1'b1;
      else
        lvl = lvl - 3'd1;
    end
    if ($urandom_range(0, 19) == 0) send_stray({$urandom, $urandom});
  endtask

  // stimulus and verdict
  initial begin
    ptw_pkg::pa_t root;
    int           phase_end;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = ptw_pkg::REG_TABLE_ROOT;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    settings_used = 0;
    cur_five   = 1'b0;
    gaps_on    = 1'b1;
    stall_on   = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // five-level walks from the highest table root
    set_config('1, 1'b1);
    send_request('1);
    send_entry(FULL_ENTRY);
    send_request('0);
    send_entry(64'd0);
    send_stray(64'd0);
    send_request('1);
    repeat (4) send_entry(TABLE_ENTRY);
    send_entry(FULL_ENTRY);
    send_request(random_va());
    send_entry(TABLE_ENTRY);
    send_entry(FULL_ENTRY);
    send_request(random_va());
    repeat (3) send_entry(TABLE_ENTRY);
    send_entry(FULL_ENTRY);
    // request in the middle of a walk
    send_request(random_va());
    send_entry(TABLE_ENTRY);
    send_request('1);
    send_entry(64'd0);
    quiesce();

    // four-level walk: large bit at level 4 is ignored
    set_config('0, 1'b0);
    send_request('1);
    send_entry(64'h81);
    send_entry(64'd0);
    quiesce();

    // random walks over several register settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: root = '1;
        1: root = '0;
        2: root = ptw_pkg::pa_t'({$urandom, $urandom});
        default: root = ptw_pkg::pa_t'({$urandom, $urandom}) & ~ptw_pkg::PAGE_MASK;
      endcase
      set_config(root, logic'(ph % 2));
      gaps_on   = (ph % 5 != 2);
      stall_on  = (ph % 5 != 4);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_walk();
      quiesce();
    end

    $display("run covered %0d beats over %0d register settings", items_sent, settings_used);
    $display("results: %0d entry reads, %0d finished walks (%0d not present)",
             reads_seen, finished_seen, absent_seen);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
